@@ design/typed_stack_machine_alu_assert.svh @@
// ----------------------------------------------------------------------------
// Typed stack machine ALU assertion macros
// Concurrent assertion forms, clocked on clk_i and reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef TYPED_STACK_MACHINE_ALU_ASSERT_SVH
`define TYPED_STACK_MACHINE_ALU_ASSERT_SVH

// Same-cycle implication.
`define TSM_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define TSM_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ design/tsm_pkg.sv @@
// ----------------------------------------------------------------------------
// Typed stack machine package
// Payload types, operation and status codes, and controller interface types.
// ----------------------------------------------------------------------------
package tsm_pkg;

  localparam int unsigned StackDepth = 64;
  localparam int unsigned DataW      = 32;
  localparam int unsigned DepthW     = 7;

  localparam logic [DataW-1:0] TrueReset    = 32'd8901;
  localparam logic [DataW-1:0] FalseReset   = 32'd8900;
  localparam logic [DataW-1:0] DivZeroReset = 32'd9999;

  // Operation codes.
  localparam logic [3:0] MODE_LIT   = 4'd0;
  localparam logic [3:0] MODE_PRINT = 4'd1;
  localparam logic [3:0] MODE_ADD   = 4'd2;
  localparam logic [3:0] MODE_SUB   = 4'd3;
  localparam logic [3:0] MODE_MUL   = 4'd4;
  localparam logic [3:0] MODE_EQ    = 4'd5;
  localparam logic [3:0] MODE_DUP   = 4'd6;
  localparam logic [3:0] MODE_DROP  = 4'd7;
  localparam logic [3:0] MODE_SWAP  = 4'd8;
  localparam logic [3:0] MODE_DIV   = 4'd9;
  localparam logic [3:0] MODE_AND   = 4'd10;
  localparam logic [3:0] MODE_OR    = 4'd11;
  localparam logic [3:0] MODE_NOT   = 4'd12;
  localparam logic [3:0] MODE_LE    = 4'd13;

  // Status codes.
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_TYPE  = 3'd1;
  localparam logic [2:0] ST_UNDER = 3'd2;
  localparam logic [2:0] ST_OVER  = 3'd3;
  localparam logic [2:0] ST_DIVZ  = 3'd4;

  // Type tags.
  localparam logic TAG_INT  = 1'b0;
  localparam logic TAG_BOOL = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TRUE  = 2'd0;
  localparam logic [1:0] CFG_FALSE = 2'd1;
  localparam logic [1:0] CFG_DIVZ  = 2'd2;

  typedef struct packed {
    logic [3:0]        mode;
    logic signed [31:0] literal_value;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               print_valid;
    logic signed [31:0] printed_value;
    logic               printed_tag;
    logic [6:0]         stack_depth;
  } out_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;
    logic check;
    logic cap_b;
    logic cap_a;
    logic exec;
    logic swap2;
    logic div_wr;
    logic finish;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic skip;
    logic need2;
    logic swap;
    logic div_go;
    logic div_done;
  } sts_t;

endpackage

@@ design/tsm_div.sv @@
// ----------------------------------------------------------------------------
// Typed stack machine divider
// Radix-2 restoring signed divider, truncating, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsm_div
  import tsm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic             done_o,
  output logic [DataW-1:0] quotient_o
);

  logic             busy_q;
  logic             done_q;
  logic [4:0]       cnt_q;
  logic [DataW:0]   rem_q;
  logic [DataW-1:0] quo_q;
  logic [DataW-1:0] mag_b_q;
  logic             neg_q;

  logic [DataW-1:0] mag_a;
  logic [DataW-1:0] mag_b;
  logic [DataW:0]   rem_sh;
  logic [DataW+1:0] diff;
  logic             ge;

  // Operand magnitudes and one restoring step.
  always_comb begin
    mag_a  = dividend_i[DataW-1] ? (~dividend_i + 1'b1) : dividend_i;
    mag_b  = divisor_i[DataW-1] ? (~divisor_i + 1'b1) : divisor_i;
    rem_sh = {rem_q[DataW-1:0], quo_q[DataW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, mag_b_q};
    ge     = !diff[DataW+1];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd31;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q   <= '0;
      quo_q   <= mag_a;
      mag_b_q <= mag_b;
      neg_q   <= dividend_i[DataW-1] ^ divisor_i[DataW-1];
    end else if (busy_q) begin
      rem_q <= ge ? diff[DataW:0] : rem_sh;
      quo_q <= {quo_q[DataW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

@@ design/tsm_dp.sv @@
// ----------------------------------------------------------------------------
// Typed stack machine datapath
// Stack memory, operand registers, ALU, configuration and result register.
// ----------------------------------------------------------------------------
module tsm_dp
  import tsm_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_t         in_data_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output out_t        out_data_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned PW = $clog2(STACK_DEPTH + 1);

  // Stack memory: value and tag per entry.
  logic [DataW:0] stack_mem [STACK_DEPTH];
  logic [DataW:0] rd_q;

  logic [3:0]       mode_q;
  logic [DataW-1:0] lit_q;
  logic [PW-1:0]    sp_q;
  logic [DataW-1:0] a_q, b_q;
  logic             ta_q, tb_q;
  logic [2:0]       stat_q;
  logic             pv_q;
  logic [DataW-1:0] pval_q;
  logic             ptag_q;
  logic [DataW-1:0] true_q, false_q, divz_q;
  out_t             out_q;

  logic [1:0]       need;
  logic             grows;
  logic             nop;
  logic             under, over;
  logic [PW-1:0]    sp_m1, sp_m2;
  logic [AW-1:0]    rd_addr;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [DataW:0]   wdata;

  logic             ints, bools, ok, div_go, divz;
  logic [DataW-1:0] r;
  logic             rt;
  logic             div_done;
  logic [DataW-1:0] quotient;

  // Operand count and growth per operation.
  always_comb begin
    need  = 2'd0;
    grows = 1'b0;
    nop   = 1'b0;
    unique case (mode_q)
      MODE_LIT:                         grows = 1'b1;
      MODE_DUP:   begin need = 2'd1; grows = 1'b1; end
      MODE_PRINT, MODE_DROP, MODE_NOT:  need = 2'd1;
      MODE_ADD, MODE_SUB, MODE_MUL, MODE_EQ, MODE_SWAP,
      MODE_DIV, MODE_AND, MODE_OR, MODE_LE: need = 2'd2;
      default:                          nop = 1'b1;
    endcase
    under = sp_q < PW'(need);
    over  = grows && (sp_q == PW'(STACK_DEPTH));
    sp_m1 = sp_q - PW'(1);
    sp_m2 = sp_q - PW'(2);
    rd_addr = cmd_i.check ? sp_m1[AW-1:0] : sp_m2[AW-1:0];
  end

  // ALU for two-operand operations; a is below the top, b is the top.
  always_comb begin
    ints  = (ta_q == TAG_INT) && (tb_q == TAG_INT);
    bools = (ta_q == TAG_BOOL) && (tb_q == TAG_BOOL);
    ok    = ints;
    r     = '0;
    rt    = TAG_INT;
    divz  = 1'b0;
    unique case (mode_q)
      MODE_ADD: r = a_q + b_q;
      MODE_SUB: r = a_q - b_q;
      MODE_MUL: r = a_q * b_q;
      MODE_DIV: begin
        r    = divz_q;
        divz = (b_q == '0);
      end
      MODE_LE: begin
        rt = TAG_BOOL;
        r  = ($signed(a_q) <= $signed(b_q)) ? true_q : false_q;
      end
      MODE_EQ: begin
        ok = (ta_q == tb_q);
        rt = TAG_BOOL;
        r  = (a_q == b_q) ? true_q : false_q;
      end
      MODE_AND: begin
        ok = bools;
        rt = TAG_BOOL;
        r  = (a_q == true_q && b_q == true_q) ? true_q : false_q;
      end
      default: begin
        ok = bools;
        rt = TAG_BOOL;
        r  = (a_q == false_q && b_q == false_q) ? false_q : true_q;
      end
    endcase
    div_go = (mode_q == MODE_DIV) && ints && !divz;
  end

  // Stack write port selection.
  always_comb begin
    we    = 1'b0;
    waddr = sp_q[AW-1:0];
    wdata = {TAG_INT, lit_q};
    if (cmd_i.check) begin
      we = !under && !over && (mode_q == MODE_LIT);
    end else if (cmd_i.exec) begin
      unique case (mode_q)
        MODE_DUP: begin
          we    = 1'b1;
          wdata = {tb_q, b_q};
        end
        MODE_NOT: begin
          we    = (tb_q == TAG_BOOL);
          waddr = sp_m1[AW-1:0];
          wdata = {TAG_BOOL, (b_q == false_q) ? true_q : false_q};
        end
        MODE_SWAP: begin
          we    = 1'b1;
          waddr = sp_m1[AW-1:0];
          wdata = {ta_q, a_q};
        end
        MODE_PRINT, MODE_DROP: we = 1'b0;
        default: begin
          we    = ok && !div_go;
          waddr = sp_m2[AW-1:0];
          wdata = {rt, r};
        end
      endcase
    end else if (cmd_i.swap2) begin
      we    = 1'b1;
      waddr = sp_m2[AW-1:0];
      wdata = {tb_q, b_q};
    end else if (cmd_i.div_wr) begin
      we    = 1'b1;
      waddr = sp_m2[AW-1:0];
      wdata = {TAG_INT, quotient};
    end
  end

  // Stack memory with registered read.
  always_ff @(posedge clk_i) begin
    if (we) begin
      stack_mem[waddr] <= wdata;
    end
    if (cmd_i.check || cmd_i.cap_b) begin
      rd_q <= stack_mem[rd_addr];
    end
  end

  // Stack pointer and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q    <= '0;
      true_q  <= TrueReset;
      false_q <= FalseReset;
      divz_q  <= DivZeroReset;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TRUE:  true_q  <= cfg_data_i;
          CFG_FALSE: false_q <= cfg_data_i;
          CFG_DIVZ:  divz_q  <= cfg_data_i;
          default:   ;
        endcase
      end
      if (cmd_i.check && !under && !over && mode_q == MODE_LIT) begin
        sp_q <= sp_q + PW'(1);
      end else if (cmd_i.exec) begin
        if (mode_q == MODE_DUP) begin
          sp_q <= sp_q + PW'(1);
        end else if (mode_q == MODE_PRINT || mode_q == MODE_DROP) begin
          sp_q <= sp_m1;
        end else if (need == 2'd2 && mode_q != MODE_SWAP && ok && !div_go) begin
          sp_q <= sp_m1;
        end
      end else if (cmd_i.div_wr) begin
        sp_q <= sp_m1;
      end
    end
  end

  // Item, operand and per-item result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= in_data_i.mode;
      lit_q  <= in_data_i.literal_value;
      stat_q <= ST_OK;
      pv_q   <= 1'b0;
      pval_q <= '0;
      ptag_q <= TAG_INT;
    end
    if (cmd_i.check) begin
      if (under) begin
        stat_q <= ST_UNDER;
      end else if (over) begin
        stat_q <= ST_OVER;
      end
    end
    if (cmd_i.cap_b) begin
      b_q  <= rd_q[DataW-1:0];
      tb_q <= rd_q[DataW];
    end
    if (cmd_i.cap_a) begin
      a_q  <= rd_q[DataW-1:0];
      ta_q <= rd_q[DataW];
    end
    if (cmd_i.exec) begin
      if (mode_q == MODE_PRINT) begin
        pv_q   <= 1'b1;
        pval_q <= b_q;
        ptag_q <= tb_q;
      end else if (mode_q == MODE_NOT) begin
        if (tb_q != TAG_BOOL) begin
          stat_q <= ST_TYPE;
        end
      end else if (need == 2'd2 && mode_q != MODE_SWAP) begin
        if (!ok) begin
          stat_q <= ST_TYPE;
        end else if (divz) begin
          stat_q <= ST_DIVZ;
        end
      end
    end
    if (cmd_i.finish) begin
      out_q.status        <= stat_q;
      out_q.print_valid   <= pv_q;
      out_q.printed_value <= pval_q;
      out_q.printed_tag   <= ptag_q;
      out_q.stack_depth   <= DepthW'(sp_q);
    end
  end

  // Iterative divider.
  tsm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.exec && div_go),
    .dividend_i (a_q),
    .divisor_i  (b_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Status to the controller.
  always_comb begin
    sts_o.skip     = under || over || nop || (mode_q == MODE_LIT);
    sts_o.need2    = (need == 2'd2);
    sts_o.swap     = (mode_q == MODE_SWAP);
    sts_o.div_go   = div_go;
    sts_o.div_done = div_done;
  end

  assign out_data_o = out_q;

endmodule

@@ design/tsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// Typed stack machine controller
// Sequences check, operand reads, execution, swap and division write-back and result handoff.
// ----------------------------------------------------------------------------
module tsm_ctrl
  import tsm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  `include "typed_stack_machine_alu_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_RDB, S_RDA, S_EXEC, S_SWAP2, S_DIVW, S_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // Commands decoded from the state.
  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.check  = (state_q == S_CHECK);
    cmd_o.cap_b  = (state_q == S_RDB);
    cmd_o.cap_a  = (state_q == S_RDA);
    cmd_o.exec   = (state_q == S_EXEC);
    cmd_o.swap2  = (state_q == S_SWAP2);
    cmd_o.div_wr = (state_q == S_DIVW) && sts_i.div_done;
    cmd_o.finish = (state_q == S_FIN) && out_free;
  end

  // State and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE:  if (in_valid_i) state_q <= S_CHECK;
        S_CHECK: state_q <= sts_i.skip ? S_FIN : S_RDB;
        S_RDB:   state_q <= sts_i.need2 ? S_RDA : S_EXEC;
        S_RDA:   state_q <= S_EXEC;
        S_EXEC: begin
          if (sts_i.swap) begin
            state_q <= S_SWAP2;
          end else if (sts_i.div_go) begin
            state_q <= S_DIVW;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_SWAP2: state_q <= S_FIN;
        S_DIVW:  if (sts_i.div_done) state_q <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  `TSM_ASSERT_NEXT(a_accept_to_check, in_valid_i && !in_stall_o, state_q == S_CHECK, "no check")
  `TSM_ASSERT_IMPL(a_div_done_in_wait, sts_i.div_done, state_q == S_DIVW, "stray divider done")
  `TSM_ASSERT_IMPL(a_rise_from_fin, $rose(out_valid_q), $past(state_q) == S_FIN, "stray result")

endmodule

@@ design/typed_stack_machine_alu.sv @@
// ----------------------------------------------------------------------------
// Typed stack machine ALU
// Executes one stack primitive per input beat on a tagged data stack.
//
//   channel | valid      | stall       | payload
//   input   | in_valid_i | in_stall_o  | in_data_i  (in_t)
//   output  | out_valid_o| out_stall_i | out_data_o (out_t)
//   config  | cfg_we_i   | none        | cfg_idx_i, cfg_data_i
//
// An item runs check, then operand reads and execution, followed by a second
// write for swap or a wait on the 32-step bit-serial divider for a divide;
// lit, underflow, overflow and unused modes go from check straight to the
// result. Type errors and divide by zero end at execution.
// The stack lives in a single-port-write memory with a registered read.
// Reset empties the stack; no clearing pass is needed.
// A result held by out_stall_i stalls the next item at its result handoff, and so also holds off further input.
// ----------------------------------------------------------------------------
module typed_stack_machine_alu
  import tsm_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // Control sequencer.
  tsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Stack and arithmetic.
  tsm_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

endmodule
